// File: rtl/integer_set_table_top_assert.svh
// assertion macros shared by the integer set table modules
`ifndef INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_TABLE_TOP_ASSERT_SVH

// expr must hold in any cycle where cond holds
`define IST_ASSERT_HOLDS(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("integer set table: assertion failed");

// expr must hold in the cycle after cond holds
`define IST_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("integer set table: assertion failed");

`endif

// File: rtl/ist_pkg.sv
package ist_pkg;

    // default number of set entries
    localparam int DEFAULT_CAPACITY = 64;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // operation codes
    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_TEST    = 3'd2,
        KIND_EXTRACT = 3'd3,
        KIND_CLEAR   = 3'd4
    } ist_kind_t;

    // input item
    typedef struct packed {
        logic [2:0]                kind;
        logic signed [VALUE_W-1:0] operand_value;
    } ist_req_t;

    // result item
    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] result_value;
        logic [COUNT_W-1:0]        element_count;
    } ist_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // latch the item, rewind the index
        logic step;        // issue one read at the index
        logic move;        // shift read data down one place
        logic seek;        // restart the index just past the matched entry
        logic append;      // write the operand at the end
        logic drop;        // one entry fewer
        logic clear_all;   // empty the set
        logic finish;      // load the result register
        logic ok;          // success flag for the result
        logic give_value;  // result carries the extracted entry
    } ist_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       full;
        logic       match;
        logic       run_end;
    } ist_status_t;

endpackage

// File: rtl/ist_ctrl.sv
`include "integer_set_table_top_assert.svh"

module ist_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ist_pkg::ist_status_t status,
    output ist_pkg::ist_cmd_t    cmd
);
    import ist_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    KIND_ADD:
                    begin
                        if (status.full)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.step   = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    KIND_REMOVE, KIND_TEST:
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    KIND_EXTRACT:
                    begin
                        if (status.empty)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.step   = 1'b1;
                            cmd.move   = 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        cmd.finish    = 1'b1;
                        cmd.ok        = !status.empty;
                        state_next    = ST_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // compare one entry a cycle while the next read is in flight
                if (status.match)
                begin
                    if (status.kind == KIND_REMOVE)
                    begin
                        cmd.seek   = 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.ok     = (status.kind == KIND_TEST);
                        state_next = ST_IDLE;
                    end
                end
                else if (status.run_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    if (status.kind == KIND_ADD)
                    begin
                        cmd.append = 1'b1;
                        cmd.ok     = 1'b1;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // close the gap one entry a cycle
                if (status.run_end)
                begin
                    cmd.drop       = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.ok         = 1'b1;
                    cmd.give_value = (status.kind == KIND_EXTRACT);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cmd.move = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    `IST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `IST_ASSERT_NEXT(a_finish_idle, cmd.finish, !busy)
    `IST_ASSERT_HOLDS(a_drop_ends, cmd.drop, cmd.finish && (state_reg == ST_SHIFT))

endmodule

// File: rtl/ist_dp.sv
`include "integer_set_table_top_assert.svh"

module ist_dp #(
    parameter int CAPACITY = ist_pkg::DEFAULT_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ist_pkg::ist_req_t    request,
    input  ist_pkg::ist_cmd_t    cmd,
    output ist_pkg::ist_status_t status,
    output logic                 done,
    output ist_pkg::ist_rsp_t    response
);
    import ist_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    // entry store, oldest entry at address zero
    logic signed [VALUE_W-1:0] entry_mem [CAPACITY];

    logic [2:0]                kind_reg;
    logic signed [VALUE_W-1:0] operand_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_vld_reg;
    logic [ADDR_W-1:0]         rd_idx_reg;

    logic                      shift_wr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    logic signed [VALUE_W-1:0] taken_reg;
    logic                      done_reg;
    ist_rsp_t                  rsp_reg;

    // read issue and index update
    assign rd_en   = cmd.step && (idx_reg < count_reg);
    assign rd_addr = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.seek)
        begin
            idx_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
        end
        else if (rd_en)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // write port: shift an entry down one place, or append at the end
    assign shift_wr = cmd.move && rd_vld_reg && (rd_idx_reg != '0);
    assign wr_en    = shift_wr || cmd.append;
    assign wr_addr  = shift_wr ? (rd_idx_reg - ADDR_W'(1)) : count_reg[ADDR_W-1:0];
    assign wr_data  = shift_wr ? rd_data_reg : operand_reg;

    // entry count
    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.clear_all)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg <= request.kind;
            end
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_en;
            rd_idx_reg <= rd_addr;
            done_reg   <= cmd.finish;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            operand_reg <= request.operand_value;
        end
        if (cmd.move && rd_vld_reg && (rd_idx_reg == '0))
        begin
            taken_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            rsp_reg.ok            <= cmd.ok;
            rsp_reg.result_value  <= cmd.give_value ? taken_reg : '0;
            rsp_reg.element_count <= COUNT_W'(count_next);
        end
    end

    // status to the controller
    assign status.kind    = kind_reg;
    assign status.empty   = (count_reg == '0);
    assign status.full    = (count_reg == CNT_MAX);
    assign status.match   = rd_vld_reg && (rd_data_reg == operand_reg);
    assign status.run_end = (idx_reg >= count_reg) && !rd_vld_reg;

    assign done     = done_reg;
    assign response = rsp_reg;

    `IST_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= CNT_MAX)
    `IST_ASSERT_HOLDS(a_write_in_range, wr_en, CNT_W'(wr_addr) <= count_reg)
    `IST_ASSERT_HOLDS(a_append_room, cmd.append, count_reg < CNT_MAX)
    `IST_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)

endmodule

// File: rtl/integer_set_table_top.sv
// channel   ports                    handshake
// input     request (ist_req_t)      taken at a clock edge with start high and busy low
// result    response (ist_rsp_t)     valid for one cycle while done is high
//
// clear, a failed add on a full set, extract on an empty set and unused
// codes finish from decode without reading the store.
// add, remove and membership test scan the store one entry a cycle through
// the single read port; remove of the entry at position p (0 for the oldest)
// finds it and then shifts the later entries down one place.
// extract reads the oldest entry and shifts the rest down.
// reset empties the set at once; the receiver cannot stall, and a new item
// may start in the same cycle that done is high.
module integer_set_table_top #(
    parameter int CAPACITY = ist_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ist_pkg::ist_req_t request,
    output logic              done,
    output ist_pkg::ist_rsp_t response
);
    import ist_pkg::*;

    ist_cmd_t    cmd;
    ist_status_t status;

    // sequencer
    ist_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // entry store, count and result register
    ist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .response (response)
    );

endmodule

// File: tb/integer_set_table_top_tb.sv
`timescale 1ns / 1ps

module integer_set_table_top_tb;

    import ist_pkg::*;

    localparam int CAPACITY      = DEFAULT_CAPACITY;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int MAX_GAP       = 18;
    localparam int POOL_N        = 96;
    localparam int MAX_SHOWN     = 10;
    // the longest item is a remove or extract on a full set
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    // the limit allows for 1700 items at worst gap plus worst scan and shift
    localparam int CYCLE_LIMIT   = 1_000_000;

    // highest code the kind field can carry
    localparam logic [2:0] KIND_TOP = 3'd7;

    localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MOST_POS = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [VALUE_W-1:0] ZERO_VAL = 32'h0000_0000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } op_mix_t;

    // shadow copy of the set, predicts each result and checks it on arrival
    class set_shadow;
        logic [VALUE_W-1:0] held [CAPACITY];
        int unsigned        held_n;
        ist_rsp_t           pending_results [$];
        int unsigned        n_items;
        int unsigned        n_checked;
        int unsigned        n_bad;
        int unsigned        peak_n;
        int unsigned        full_refusals;

        function new();
            held_n        = 0;
            n_items       = 0;
            n_checked     = 0;
            n_bad         = 0;
            peak_n        = 0;
            full_refusals = 0;
        endfunction

        // position of v among held entries, -1 if absent
        function int find_held(logic [VALUE_W-1:0] v);
            int pos;
            pos = -1;
            for (int i = 0; i < held_n; i++)
            begin
                if (pos < 0 && held[i] == v)
                    pos = i;
            end
            return pos;
        endfunction

        // close the gap left at pos
        function void drop_held(int pos);
            for (int i = pos; i + 1 < held_n; i++)
                held[i] = held[i + 1];
            held_n--;
        endfunction

        function void note_request(ist_req_t req);
            ist_rsp_t rsp;
            int       pos;
            rsp = '0;
            case (req.kind)
                KIND_ADD:
                begin
                    if (held_n < CAPACITY && find_held(req.operand_value) < 0)
                    begin
                        held[held_n] = req.operand_value;
                        held_n++;
                        rsp.ok = 1'b1;
                    end
                    else if (held_n == CAPACITY)
                    begin
                        full_refusals++;
                    end
                end
                KIND_REMOVE:
                begin
                    pos = find_held(req.operand_value);
                    if (pos >= 0)
                    begin
                        drop_held(pos);
                        rsp.ok = 1'b1;
                    end
                end
                KIND_TEST:
                    rsp.ok = (find_held(req.operand_value) >= 0);
                KIND_EXTRACT:
                begin
                    if (held_n > 0)
                    begin
                        rsp.result_value = held[0];
                        drop_held(0);
                        rsp.ok = 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    rsp.ok = (held_n > 0);
                    held_n = 0;
                end
                default:
                    ;
            endcase
            rsp.element_count = COUNT_W'(held_n);
            pending_results.push_back(rsp);
            n_items++;
            if (held_n > peak_n)
                peak_n = held_n;
        endfunction

        function void check_result(ist_rsp_t got);
            ist_rsp_t want;
            if (pending_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= MAX_SHOWN)
                    $display("[%0t] result with no item waiting: ok=%0b value=%0d count=%0d",
                             $time, got.ok, got.result_value, got.element_count);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.ok !== want.ok || got.result_value !== want.result_value
                || got.element_count !== want.element_count)
            begin
                n_bad++;
                if (n_bad <= MAX_SHOWN)
                    $display("[%0t] result %0d: ok %0b/%0b value %0d/%0d count %0d/%0d (exp/got)",
                             $time, n_checked, want.ok, got.ok, want.result_value,
                             got.result_value, want.element_count, got.element_count);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    ist_req_t    request;
    ist_rsp_t    response;
    int unsigned cycle_n = 0;

    set_shadow          shadow = new();
    logic [VALUE_W-1:0] value_pool [POOL_N];

    integer_set_table_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // every result is taken at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result(response);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_n);
            $display("FAIL");
            $finish;
        end
    end

    // present one item after an idle gap and hold it until it is taken
    task automatic send_item(ist_req_t item, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        shadow.note_request(item);
    endtask

    task automatic send_op(logic [2:0] kind, logic [VALUE_W-1:0] value);
        ist_req_t item;
        item.kind          = kind;
        item.operand_value = value;
        send_item(item, $urandom_range(MAX_GAP, 0));
    endtask

    // mostly values from a shared pool so that hits and duplicates are common
    function automatic logic [VALUE_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return value_pool[$urandom_range(POOL_N - 1, 0)];
        if (roll < 80)
        begin
            case ($urandom_range(3, 0))
                0: return MOST_NEG;
                1: return MOST_POS;
                2: return ZERO_VAL;
                default: return ALL_ONES;
            endcase
        end
        return $urandom;
    endfunction

    function automatic ist_req_t random_item(op_mix_t mix);
        ist_req_t item;
        int       roll;
        int       add_w;
        int       remove_w;
        int       test_w;
        int       extract_w;
        int       clear_w;
        roll = $urandom_range(99, 0);
        case (mix)
            MIX_FILL:
            begin
                add_w = 75; remove_w = 6; test_w = 10; extract_w = 5; clear_w = 1;
            end
            MIX_DRAIN:
            begin
                add_w = 15; remove_w = 35; test_w = 10; extract_w = 35; clear_w = 2;
            end
            default:
            begin
                add_w = 35; remove_w = 20; test_w = 20; extract_w = 17; clear_w = 3;
            end
        endcase
        item.operand_value = pick_operand();
        if (roll < add_w)
            item.kind = KIND_ADD;
        else if (roll < add_w + remove_w)
            item.kind = KIND_REMOVE;
        else if (roll < add_w + remove_w + test_w)
            item.kind = KIND_TEST;
        else if (roll < add_w + remove_w + test_w + extract_w)
            item.kind = KIND_EXTRACT;
        else if (roll < add_w + remove_w + test_w + extract_w + clear_w)
            item.kind = KIND_CLEAR;
        else
            item.kind = 3'($urandom_range(KIND_TOP, KIND_CLEAR + 1));
        return item;
    endfunction

    // stimulus
    initial
    begin
        int       sent;
        int       burst_len;
        bit       no_gaps;
        op_mix_t  mix;
        ist_req_t item;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        sent    = 0;

        // small signed values in part of the pool, the rest spread over the range
        for (int i = 0; i < POOL_N; i++)
            value_pool[i] = (i < 16) ? VALUE_W'(i - 8) : VALUE_W'($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, duplicates, hits and misses, empty and unused codes
        send_op(KIND_ADD, MOST_NEG);
        send_op(KIND_ADD, MOST_POS);
        send_op(KIND_ADD, ZERO_VAL);
        send_op(KIND_ADD, ALL_ONES);
        send_op(KIND_ADD, MOST_POS);
        send_op(KIND_TEST, MOST_POS);
        send_op(KIND_TEST, 32'h0000_0001);
        send_op(KIND_REMOVE, 32'h0000_3039);
        send_op(KIND_REMOVE, ZERO_VAL);
        send_op(KIND_TEST, ZERO_VAL);
        send_op(KIND_EXTRACT, $urandom);
        send_op(KIND_ADD, 32'h5555_5555);
        send_op(KIND_ADD, 32'haaaa_aaaa);
        send_op(KIND_REMOVE, ALL_ONES);
        send_op(KIND_EXTRACT, ZERO_VAL);
        send_op(KIND_CLEAR, $urandom);
        send_op(KIND_CLEAR, $urandom);
        send_op(KIND_EXTRACT, $urandom);
        send_op(KIND_REMOVE, MOST_NEG);
        send_op(KIND_TEST, ALL_ONES);
        for (int k = KIND_CLEAR + 1; k <= KIND_TOP; k++)
            send_op(3'(k), $urandom);
        send_op(KIND_ADD, ALL_ONES);
        send_op(KIND_EXTRACT, $urandom);

        // random bursts, each with its own operation mix and idle pattern
        while (sent < RANDOM_ITEMS)
        begin
            mix       = op_mix_t'($urandom_range(MIX_BALANCED, MIX_FILL));
            burst_len = (mix == MIX_FILL) ? $urandom_range(160, 60) : $urandom_range(100, 20);
            no_gaps   = ($urandom_range(3, 0) == 0);
            for (int j = 0; j < burst_len; j++)
            begin
                item = random_item(mix);
                send_item(item, no_gaps ? 0 : $urandom_range(MAX_GAP, 0));
                sent++;
            end
        end
        start <= 1'b0;

        // let the last results arrive, then watch for strays
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked, set reached %0d of %0d entries",
                 shadow.n_items, shadow.n_checked, shadow.peak_n, CAPACITY);
        $display("%0d adds refused on a full set, %0d mismatches",
                 shadow.full_refusals, shadow.n_bad);
        if (shadow.n_bad == 0 && shadow.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_ctrl.sv
rtl/ist_dp.sv
rtl/integer_set_table_top.sv
tb/integer_set_table_top_tb.sv
